FILE: sv/khtbl_pkg.sv
// ----------------------------------------------------------------------------
// khtbl_pkg
// Shared types and codes for the keyed handle table.
// ----------------------------------------------------------------------------
package khtbl_pkg;

  localparam int TableDepthDefault = 128;

  localparam logic [1:0] MODE_LOOKUP  = 2'd0;
  localparam logic [1:0] MODE_INSERT  = 2'd1;
  localparam logic [1:0] MODE_RELEASE = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [31:0] inst;
    logic [31:0] ident;
    logic [31:0] value;
  } entry_t;

endpackage

FILE: sv/keyed_handle_table_unit.sv
// ----------------------------------------------------------------------------
// keyed_handle_table_unit
// Ordered (instance, id) keyed table of value handles: lookup, insert,
// release with gap compaction.
// ----------------------------------------------------------------------------
// channel   ports                                    handshake
// request   mode key_instance key_id value_in        start & !busy
// result    status value_out entry_count             done, one cycle
//
// Insert: result in the cycle after the request, busy stays low.
// Lookup/release: entries are scanned in order through the single read
// port; on a release hit each later entry moves up one place in place of
// its scan.
// Reset clears the state, the entry count and done; entry memory is not cleared.
// The receiver cannot stall; results are registered, so a new request may
// be taken while a result is on the ports.
module keyed_handle_table_unit import khtbl_pkg::*; #(
  parameter int TABLE_DEPTH = TableDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [31:0] key_instance,
  input  logic [31:0] key_id,
  input  logic [31:0] value_in,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] value_out,
  output logic [7:0]  entry_count
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_SHIFT = 3'b100
  } state_t;

  state_t        state;
  logic [CW-1:0] count;
  logic [AW-1:0] idx;
  logic          is_release;
  logic [31:0]   req_inst;
  logic [31:0]   req_ident;

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  entry_t        wr_data, rd_data;

  logic [CW-1:0] idx_p1, idx_p2;
  logic          hit;
  logic [CW+7:0] count_next_ext;
  logic [CW-1:0] count_next;
  logic          res_fire;
  logic [1:0]    res_status;
  logic [31:0]   res_value;

  assign idx_p1 = CW'(idx) + CW'(1);
  assign idx_p2 = CW'(idx) + CW'(2);
  assign hit    = (rd_data.inst == req_inst) && (rd_data.ident == req_ident);
  assign busy   = (state != S_IDLE);

  khtbl_mem #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = count[AW-1:0];
    wr_data    = '{inst: key_instance, ident: key_id, value: value_in};
    rd_en      = 1'b0;
    rd_addr    = '0;
    count_next = count;
    res_fire   = 1'b0;
    res_status = ST_DONE;
    res_value  = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (mode == MODE_INSERT) begin
            res_fire = 1'b1;
            if (count >= DepthC) begin
              res_status = ST_FULL;
            end else begin
              wr_en      = 1'b1;
              count_next = count + CW'(1);
            end
          end else if (count == '0) begin
            res_fire   = 1'b1;
            res_status = ST_MISS;
          end else begin
            rd_en = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          if (!is_release) begin
            res_fire  = 1'b1;
            res_value = rd_data.value;
          end else if (idx_p1 < count) begin
            rd_en   = 1'b1;
            rd_addr = idx_p1[AW-1:0];
          end else begin
            res_fire   = 1'b1;
            count_next = count - CW'(1);
          end
        end else if (idx_p1 < count) begin
          rd_en   = 1'b1;
          rd_addr = idx_p1[AW-1:0];
        end else begin
          res_fire   = 1'b1;
          res_status = ST_MISS;
        end
      end
      S_SHIFT: begin
        // rd_data holds entry idx+1; move it up one place
        wr_en   = 1'b1;
        wr_addr = idx;
        wr_data = rd_data;
        if (idx_p2 < count) begin
          rd_en   = 1'b1;
          rd_addr = idx_p2[AW-1:0];
        end else begin
          res_fire   = 1'b1;
          count_next = count - CW'(1);
        end
      end
      default: ;
    endcase
    count_next_ext = {8'd0, count_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= res_fire;
      unique case (state)
        S_IDLE: begin
          if (start && mode != MODE_INSERT && count != '0) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit && is_release && idx_p1 < count) begin
            state <= S_SHIFT;
          end else if (hit || !(idx_p1 < count)) begin
            state <= S_IDLE;
          end
        end
        S_SHIFT: begin
          if (!(idx_p2 < count)) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      idx        <= '0;
      is_release <= (mode == MODE_RELEASE);
      req_inst   <= key_instance;
      req_ident  <= key_id;
    end else if (state == S_SCAN && !hit && idx_p1 < count) begin
      idx <= idx_p1[AW-1:0];
    end else if (state == S_SHIFT) begin
      idx <= idx_p1[AW-1:0];
    end
    if (res_fire) begin
      status      <= res_status;
      value_out   <= res_value;
      entry_count <= count_next_ext[7:0];
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DepthC) else $error("entry count above depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode == MODE_INSERT && count < DepthC)
      |=> (count == $past(count) + CW'(1)) && done)
    else $error("insert did not add an entry");

  a_shift_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> (count != '0 && is_release))
    else $error("compaction without a release");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(res_fire)) else $error("result without a finished request");
`endif

endmodule

FILE: sv/khtbl_mem.sv
// ----------------------------------------------------------------------------
// khtbl_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module khtbl_mem import khtbl_pkg::*; #(
  parameter int DEPTH = TableDepthDefault,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for keyed_handle_table_unit: drives lookup, insert and
// release requests, predicts status, value and entry count from a local
// ordered table, and compares every result strobe against the prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import khtbl_pkg::*;

  localparam int Depth = TableDepthDefault;
  localparam int StallLimit = 2000;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value;
    logic [7:0]  count;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  mode = MODE_LOOKUP;
  logic [31:0] key_instance = '0;
  logic [31:0] key_id = '0;
  logic [31:0] value_in = '0;
  logic        done;
  logic [1:0]  status;
  logic [31:0] value_out;
  logic [7:0]  entry_count;

  // local copy of the table contents, oldest entry first
  entry_t table_q[$];
  reply_t pending_q[$];
  int     errors = 0;
  int     idle_pct = 0;
  int     idle_cycles = 0;
  int     sent = 0;
  int     hits = 0;
  int     fulls = 0;
  int     misses = 0;

  keyed_handle_table_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .key_instance(key_instance), .key_id(key_id), .value_in(value_in),
    .done(done), .status(status), .value_out(value_out),
    .entry_count(entry_count)
  );

  always #6 clk = ~clk;

  function automatic reply_t apply_request(logic [1:0] m, logic [31:0] ki,
                                           logic [31:0] kd, logic [31:0] v);
    reply_t r;
    int pos;
    entry_t e;
    r = '0;
    pos = -1;
    foreach (table_q[i])
      if (pos < 0 && table_q[i].inst == ki && table_q[i].ident == kd) pos = i;
    if (m == MODE_INSERT) begin
      if (table_q.size() >= Depth) begin
        r.status = ST_FULL;
      end else begin
        e.inst = ki;
        e.ident = kd;
        e.value = v;
        table_q.push_back(e);
      end
    end else if (m == MODE_RELEASE) begin
      if (pos < 0) r.status = ST_MISS;
      else table_q.delete(pos);
    end else begin
      if (pos < 0) r.status = ST_MISS;
      else r.value = table_q[pos].value;
    end
    r.count = 8'(table_q.size());
    return r;
  endfunction

  // start stays high after the accepting edge until the next idle gap or drain
  task automatic send(logic [1:0] m, logic [31:0] ki, logic [31:0] kd,
                      logic [31:0] v);
    reply_t r;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    mode <= m;
    key_instance <= ki;
    key_id <= kd;
    value_in <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = apply_request(m, ki, kd, v);
    if (r.status == ST_FULL) fulls++;
    else if (r.status == ST_MISS) misses++;
    else if (m != MODE_INSERT && m != MODE_RELEASE) hits++;
    pending_q.push_back(r);
    sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_q.size() > 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    reply_t exp_r;
    if (!rst && done) begin
      if (pending_q.size() == 0) begin
        $error("result with nothing pending");
        errors++;
      end else begin
        exp_r = pending_q.pop_front();
        if (status !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, status);
          errors++;
        end
        if (value_out !== exp_r.value) begin
          $error("value_out exp %h got %h", exp_r.value, value_out);
          errors++;
        end
        if (entry_count !== exp_r.count) begin
          $error("entry_count exp %0d got %0d", exp_r.count, entry_count);
          errors++;
        end
      end
    end
  end

  // counts cycles with no request or result taken
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // a key drawn from a small pool so that hits and duplicates are common
  function automatic logic [63:0] pool_key();
    logic [63:0] k;
    k = {32'h8000_0000 ^ $urandom_range(3), 32'h7fff_fffc + $urandom_range(3)};
    if ($urandom_range(9) == 0) k = {$urandom, $urandom};
    return k;
  endfunction

  task automatic test_extremes();
    logic [31:0] ext [4] = '{32'h0, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff};
    send(MODE_LOOKUP, '0, '0, '0);
    send(MODE_RELEASE, '0, '0, '0);
    foreach (ext[i]) send(MODE_INSERT, ext[i], ext[3 - i], ext[i] ^ 32'h5a5a_a5a5);
    send(MODE_INSERT, ext[1], ext[2], 32'h1234_5678); // duplicate key
    foreach (ext[i]) send(MODE_LOOKUP, ext[i], ext[3 - i], '1);
    send(2'd3, ext[1], ext[2], '0); // unused mode reads as lookup
    send(MODE_RELEASE, ext[1], ext[2], '0);
    send(MODE_LOOKUP, ext[1], ext[2], '0);
    send(MODE_RELEASE, ext[0], ext[0], '0);
    send(MODE_RELEASE, ext[0], ext[3], '0);
    send(MODE_LOOKUP, ext[2], ext[1], '0);
    drain();
  endtask

  task automatic test_full_table();
    int n;
    n = 0;
    while (table_q.size() < Depth) begin
      send(MODE_INSERT, n, ~n, $urandom);
      n++;
    end
    send(MODE_INSERT, '1, '1, '1);
    send(MODE_LOOKUP, n - 1, ~(n - 1), '0);
    send(MODE_RELEASE, 0, ~0, '0);
    send(MODE_INSERT, 32'h8000_0000, 32'h7fff_ffff, '1);
    send(MODE_INSERT, '0, '0, '0);
    while (table_q.size() > 0)
      send(MODE_RELEASE, table_q[$].inst, table_q[$].ident, '0);
    drain();
  endtask

  task automatic test_random(int pct, int items);
    logic [63:0] k;
    int pick;
    idle_pct = pct;
    repeat (items) begin
      k = pool_key();
      pick = $urandom_range(99);
      if (pick < 40 && table_q.size() < Depth)
        send(MODE_INSERT, k[63:32], k[31:0], $urandom);
      else if (pick < 70) send(MODE_RELEASE, k[63:32], k[31:0], $urandom);
      else send(2'($urandom_range(3)), k[63:32], k[31:0], $urandom);
    end
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_full_table();
    test_random(20, 160);
    test_random(48, 160);
    test_random(0, 160);
    repeat (2 * Depth + 10) @(posedge clk);
    $display("Covered %0d requests: %0d lookup hits, %0d misses, %0d full rejects.",
             sent, hits, misses, fulls);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
